// File: rtl/ura_pkg.sv
// shared constants, types and the digit to ascii function for the radix converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ura_pkg;

  localparam int VAL_W      = 64;
  localparam int MAX_DIGITS = 22;
  localparam int DIG_W      = MAX_DIGITS * 4;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W      = BCD_DIGITS * 4;
  localparam int EXT_W      = (DIG_W > VAL_W) ? DIG_W : VAL_W;
  localparam int CNT_W      = $clog2(VAL_W);
  localparam int REM_W      = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {
    FUNC_OCT    = 2'd0,
    FUNC_DEC    = 2'd1,
    FUNC_HEX_LO = 2'd2,
    FUNC_HEX_UP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    SIZE_32 = 2'd0,
    SIZE_64 = 2'd1,
    SIZE_16 = 2'd2
  } size_mode_t;

  localparam logic [6:0] ASCII_ZERO    = 7'h30;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;
  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [6:0] ASCII_LOWER_X = 7'h78;
  localparam logic [6:0] ASCII_UPPER_X = 7'h58;

  // converter to emitter handoff
  typedef struct packed {
    logic load;
    logic prefix;
    logic hex;
    logic upper;
  } emit_ctrl_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] base;
    begin
      base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
      if (d < 4'd10) begin
        digit_char = ASCII_ZERO + {3'b000, d};
      end else begin
        digit_char = base + {3'b000, d} - 7'd10;
      end
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/ura_conv.sv
// value truncation and binary to digit conversion, bit-serial for decimal
// octal and hex digits come straight from bit groups, decimal by serial double dabble
// depends on ura_pkg
`timescale 1ns / 1ps
`default_nettype none

module ura_conv (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire logic [ura_pkg::VAL_W-1:0]  value,
  input  wire logic [1:0]                 func,
  input  wire logic [1:0]                 size_mode,
  input  wire logic                       alt_form,
  output logic      [ura_pkg::DIG_W-1:0]  digits,
  output ura_pkg::emit_ctrl_t             ctl
);

  typedef enum logic {
    CV_IDLE,
    CV_SHIFT
  } conv_state_t;

  conv_state_t                 state;
  logic [ura_pkg::VAL_W-1:0]   sr;
  logic [ura_pkg::BCD_W-1:0]   bcd;
  logic [ura_pkg::CNT_W-1:0]   cnt;

  logic [ura_pkg::VAL_W-1:0]   trunc;
  logic [ura_pkg::EXT_W-1:0]   ext;
  logic [ura_pkg::DIG_W-1:0]   oct_dig;
  logic [ura_pkg::DIG_W-1:0]   hex_dig;
  logic [ura_pkg::BCD_W-1:0]   adj;
  logic [ura_pkg::BCD_W-1:0]   bcd_next;

  always_comb begin
    case (size_mode)
      ura_pkg::SIZE_32: trunc = {{(ura_pkg::VAL_W-32){1'b0}}, value[31:0]};
      ura_pkg::SIZE_16: trunc = {{(ura_pkg::VAL_W-16){1'b0}}, value[15:0]};
      default:          trunc = value;
    endcase
    ext = ura_pkg::EXT_W'(trunc);
    for (int i = 0; i < ura_pkg::MAX_DIGITS; i++) begin
      oct_dig[4*i +: 4] = {1'b0, ext[3*i +: 3]};
      hex_dig[4*i +: 4] = ext[4*i +: 4];
    end
    for (int j = 0; j < ura_pkg::BCD_DIGITS; j++) begin
      adj[4*j +: 4] = (bcd[4*j +: 4] >= 4'd5) ? bcd[4*j +: 4] + 4'd3 : bcd[4*j +: 4];
    end
    bcd_next = {adj[ura_pkg::BCD_W-2:0], sr[ura_pkg::VAL_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CV_IDLE;
      ctl.load <= 1'b0;
    end else begin
      ctl.load <= 1'b0;
      case (state)
        CV_IDLE: begin
          if (go) begin
            ctl.prefix <= alt_form && (value != '0) && (func != ura_pkg::FUNC_DEC);
            ctl.hex    <= (func == ura_pkg::FUNC_HEX_LO) || (func == ura_pkg::FUNC_HEX_UP);
            ctl.upper  <= (func == ura_pkg::FUNC_HEX_UP);
            if (func == ura_pkg::FUNC_DEC) begin
              sr    <= trunc;
              bcd   <= '0;
              cnt   <= '0;
              state <= CV_SHIFT;
            end else begin
              digits   <= (func == ura_pkg::FUNC_OCT) ? oct_dig : hex_dig;
              ctl.load <= 1'b1;
            end
          end
        end
        CV_SHIFT: begin
          sr  <= {sr[ura_pkg::VAL_W-2:0], 1'b0};
          bcd <= bcd_next;
          cnt <= cnt + ura_pkg::CNT_W'(1);
          if (cnt == ura_pkg::CNT_W'(ura_pkg::VAL_W - 1)) begin
            digits   <= ura_pkg::DIG_W'(bcd_next);
            ctl.load <= 1'b1;
            state    <= CV_IDLE;
          end
        end
        default: state <= CV_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/ura_emit.sv
// digit shift register: skips leading zeros, sends prefix and digits one per cycle
// depends on ura_pkg
`timescale 1ns / 1ps
`default_nettype none

module ura_emit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ura_pkg::emit_ctrl_t        ctl,
  input  wire logic [ura_pkg::DIG_W-1:0]  digits,
  output logic      [6:0]                 out_char,
  output logic                            last,
  output logic                            strobe,
  output logic                            finish
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_SKIP,
    E_PRE0,
    E_PREX,
    E_DIGIT
  } emit_state_t;

  emit_state_t                state;
  logic [ura_pkg::DIG_W-1:0]  dreg;
  logic [ura_pkg::REM_W-1:0]  rem;
  logic                       prefix_q;
  logic                       hex_q;
  logic                       upper_q;
  logic [3:0]                 top;

  assign top    = dreg[ura_pkg::DIG_W-1 -: 4];
  assign finish = (state == E_DIGIT) && (rem == ura_pkg::REM_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        E_IDLE: begin
          if (ctl.load) begin
            dreg     <= digits;
            rem      <= ura_pkg::REM_W'(ura_pkg::MAX_DIGITS);
            prefix_q <= ctl.prefix;
            hex_q    <= ctl.hex;
            upper_q  <= ctl.upper;
            state    <= E_SKIP;
          end
        end
        E_SKIP: begin
          if ((top == 4'd0) && (rem > ura_pkg::REM_W'(1))) begin
            dreg <= {dreg[ura_pkg::DIG_W-5:0], 4'b0000};
            rem  <= rem - ura_pkg::REM_W'(1);
          end else begin
            state <= prefix_q ? E_PRE0 : E_DIGIT;
          end
        end
        E_PRE0: begin
          strobe   <= 1'b1;
          out_char <= ura_pkg::ASCII_ZERO;
          last     <= 1'b0;
          state    <= hex_q ? E_PREX : E_DIGIT;
        end
        E_PREX: begin
          strobe   <= 1'b1;
          out_char <= upper_q ? ura_pkg::ASCII_UPPER_X : ura_pkg::ASCII_LOWER_X;
          last     <= 1'b0;
          state    <= E_DIGIT;
        end
        E_DIGIT: begin
          strobe   <= 1'b1;
          out_char <= ura_pkg::digit_char(top, upper_q);
          last     <= (rem == ura_pkg::REM_W'(1));
          dreg     <= {dreg[ura_pkg::DIG_W-5:0], 4'b0000};
          rem      <= rem - ura_pkg::REM_W'(1);
          if (rem == ura_pkg::REM_W'(1)) begin
            state <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/unsigned_radix_to_ascii.sv
// top level of the unsigned to ascii converter: busy control around ura_conv and ura_emit
// depends on ura_pkg, ura_conv, ura_emit
//
// channel   direction  handshake                     payload
// input     in         start high while busy low     value, func, size_mode, alt_form
// result    out        strobe high for one cycle     out_char, last
//
// octal and hex: the converter loads the digit register from the bit groups; the emitter
// then skips each leading zero digit (at most 21), sends each prefix character and digit
// decimal: serial double dabble (one value bit per cycle) runs before the register loads
// busy drops in the cycle of the last character, so a new transaction can start then
// synchronous active high reset returns both units to idle with no strobe pending
// the receiver cannot stall; every strobe carries one character of the transaction
`timescale 1ns / 1ps
`default_nettype none

module unsigned_radix_to_ascii (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ura_pkg::VAL_W-1:0]  value,
  input  wire logic [1:0]                 func,
  input  wire logic [1:0]                 size_mode,
  input  wire logic                       alt_form,
  output logic                            busy,
  output logic      [6:0]                 out_char,
  output logic                            last,
  output logic                            strobe
);

  logic                       go;
  logic                       finish;
  logic [ura_pkg::DIG_W-1:0]  digits;
  ura_pkg::emit_ctrl_t        ctl;

  assign go = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  ura_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .value     (value),
    .func      (func),
    .size_mode (size_mode),
    .alt_form  (alt_form),
    .digits    (digits),
    .ctl       (ctl)
  );

  ura_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .digits   (digits),
    .out_char (out_char),
    .last     (last),
    .strobe   (strobe),
    .finish   (finish)
  );

endmodule

`default_nettype wire
